[sv/swsc_pkg.sv]
// Shared types and constants for the sliding-window sender control block.
package swsc_pkg;

    localparam int WINDOW        = 16;
    localparam int SEQ_SPACE     = 256;
    localparam int SEQ_W         = $clog2(SEQ_SPACE);
    localparam int WIN_LIMIT     = (WINDOW > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : WINDOW;
    localparam int CNT_W         = 16;
    localparam int FLIGHT_W      = 5;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(1000);

    // request type codes
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_PKT  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // configuration register indexes (paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_FLOW    = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_NEW     = 3'd1,
        ACT_RESEND  = 3'd2,
        ACT_REFUSED = 3'd3,
        ACT_ERROR   = 3'd4
    } action_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        send_is_fin;
        logic        pkt_intact;
        logic        pkt_ack;
        logic        pkt_syn;
        logic        pkt_fin;
        logic [7:0]  ack_seq;
        logic [15:0] peer_rwnd;
    } item_t;

    typedef struct packed {
        action_t              action;
        logic [7:0]           tx_seq;
        logic                 tx_is_fin;
        logic [FLIGHT_W-1:0]  in_flight;
        logic                 is_connected;
        logic                 is_finished;
        logic                 dup_ack;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] timeout_ticks;
        logic             flow_control_on;
    } cfg_t;

endpackage

[sv/swsc_cfg.sv]
// APB configuration registers for the sliding-window sender control block.
module swsc_cfg
    import swsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [CNT_W-1:0] timeout_reg;
    logic             flow_reg;
    logic             wr_en;
    logic             reg_sel;

    // registers sit on word addresses; byte lanes below are ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            flow_reg    <= 1'b0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_TIMEOUT: timeout_reg <= pwdata[CNT_W-1:0];
                REG_FLOW:    flow_reg    <= pwdata[0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            REG_FLOW:    prdata = PDATA_W'(flow_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.timeout_ticks   = timeout_reg;
    assign cfg.flow_control_on = flow_reg;

endmodule

[sv/swsc_core.sv]
// Sender state registers and the per-event update logic.
module swsc_core
    import swsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [SEQ_W-1:0] LIMIT_S  = SEQ_W'(WIN_LIMIT);
    localparam logic [SEQ_W:0]   WINDOW_E = (SEQ_W+1)'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [15:0]      peer_win_reg, peer_win_next;
    logic [CNT_W-1:0] timer_cnt_reg, timer_cnt_next;
    logic             timer_run_reg, timer_run_next;
    logic             conn_reg, conn_next;
    logic             fin_reg, fin_next;
    logic             halt_reg, halt_next;

    logic [SEQ_W-1:0] flight;
    logic [SEQ_W-1:0] flight_after;
    logic [SEQ_W-1:0] ack_dist;
    logic [SEQ_W-1:0] ack_s;
    logic [CNT_W-1:0] cnt_inc;
    logic             send_ok;
    logic             ack_ok;

    assign ack_s    = item.ack_seq[SEQ_W-1:0];
    assign flight   = next_seq_reg - base_reg;
    assign ack_dist = ack_s - base_reg;
    assign ack_ok   = (ack_dist != '0) && ({1'b0, ack_dist} <= WINDOW_E)
                      && (ack_dist <= flight);
    assign send_ok  = (flight < LIMIT_S)
                      && !(cfg.flow_control_on && (peer_win_reg < 16'(flight)));
    assign cnt_inc  = (timer_cnt_reg < CNT_MAX) ? timer_cnt_reg + 1'b1 : timer_cnt_reg;

    always_comb begin
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        peer_win_next  = peer_win_reg;
        timer_cnt_next = timer_cnt_reg;
        timer_run_next = timer_run_reg;
        conn_next      = conn_reg;
        fin_next       = fin_reg;
        halt_next      = halt_reg;
        res.action     = ACT_NONE;
        res.tx_seq     = '0;
        res.tx_is_fin  = 1'b0;
        res.dup_ack    = 1'b0;

        if (!halt_reg) begin
            case (item.req_type)
                REQ_SEND: begin
                    if (send_ok) begin
                        res.action    = ACT_NEW;
                        res.tx_seq    = 8'(next_seq_reg);
                        res.tx_is_fin = item.send_is_fin;
                        if (flight == '0) begin
                            timer_cnt_next = '0;
                            timer_run_next = 1'b1;
                        end
                        next_seq_next = next_seq_reg + 1'b1;
                    end else begin
                        res.action = ACT_REFUSED;
                    end
                end
                REQ_PKT: begin
                    if (item.pkt_intact && !fin_reg) begin
                        if (cfg.flow_control_on) begin
                            peer_win_next = item.peer_rwnd;
                            // resume without clearing the count
                            if (item.peer_rwnd != '0) timer_run_next = 1'b1;
                        end
                        if (!item.pkt_ack) begin
                            res.action = ACT_ERROR;
                            halt_next  = 1'b1;
                        end else if (item.pkt_fin) begin
                            fin_next = 1'b1;
                        end else if (item.pkt_syn) begin
                            conn_next = 1'b1;
                        end else begin
                            if (ack_ok) base_next = ack_s;
                            else        res.dup_ack = 1'b1;
                            // stop when everything is acked, else restart
                            timer_cnt_next = '0;
                            timer_run_next = (next_seq_reg != base_next);
                        end
                    end
                end
                REQ_TICK: begin
                    if (timer_run_reg) begin
                        timer_cnt_next = cnt_inc;
                        if (cnt_inc >= cfg.timeout_ticks) begin
                            timer_cnt_next = '0;
                            if (flight != '0) begin
                                res.action     = ACT_RESEND;
                                res.tx_seq     = 8'(base_reg);
                                timer_run_next = 1'b1;
                            end else begin
                                timer_run_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        flight_after     = next_seq_next - base_next;
        res.in_flight    = flight_after[FLIGHT_W-1:0];
        res.is_connected = conn_next;
        res.is_finished  = fin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            next_seq_reg  <= '0;
            peer_win_reg  <= '0;
            timer_cnt_reg <= '0;
            timer_run_reg <= 1'b0;
            conn_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            halt_reg      <= 1'b0;
        end else if (step) begin
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            peer_win_reg  <= peer_win_next;
            timer_cnt_reg <= timer_cnt_next;
            timer_run_reg <= timer_run_next;
            conn_reg      <= conn_next;
            fin_reg       <= fin_next;
            halt_reg      <= halt_next;
        end
    end

    a_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_seq_reg - base_reg) <= LIMIT_S)
        else $error("in-flight count exceeds window limit");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halted flag cleared without reset");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.action == ACT_ERROR) |=> halt_reg)
        else $error("protocol error did not halt the sender");

    a_stopped_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_run_reg |-> (timer_cnt_reg == '0))
        else $error("stopped timer holds a nonzero count");

    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> (res.action == ACT_NONE))
        else $error("halted sender produced an action");

endmodule

[sv/sliding_window_sender_control_top.sv]
// Top level of the sliding-window sender control block: handshakes and pipeline registers.
//
//  channel  | direction | handshake         | payload
//  s_*      | in        | s_valid / s_ready | send request, received packet or timer tick
//  m_*      | out       | m_valid / m_ready | action, tx sequence, flight count and flags
//  APB      | in        | psel / penable    | timeout_ticks @0x0, flow_control_on @0x4
//
// One event per cycle sustained while m_ready stays high; m_valid rises once an s_ transfer
// has gone through both registers (the transfer loads the input register, and a later advance
// writes the state update into the result register).
// aresetn is synchronous, active low; it clears the valid flags and core state and restores register defaults.
// A stalled result holds in the output register while the input register takes one more
// event; s_ready drops only when both are full and m_ready is low.
module sliding_window_sender_control_top
    import swsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input events
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_send_is_fin,
    input  logic               s_pkt_intact,
    input  logic               s_pkt_ack,
    input  logic               s_pkt_syn,
    input  logic               s_pkt_fin,
    input  logic [7:0]         s_ack_seq,
    input  logic [15:0]        s_peer_rwnd,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_action,
    output logic [7:0]         m_tx_seq,
    output logic               m_tx_is_fin,
    output logic [4:0]         m_in_flight,
    output logic               m_is_connected,
    output logic               m_is_finished,
    output logic               m_dup_ack,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    // move the held event into the result register when that slot frees up
    assign advance = item_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    swsc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) item_valid_reg <= s_valid;
            if (advance) res_valid_reg <= 1'b1;
            else if (m_ready) res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type    <= s_req_type;
            item_reg.send_is_fin <= s_send_is_fin;
            item_reg.pkt_intact  <= s_pkt_intact;
            item_reg.pkt_ack     <= s_pkt_ack;
            item_reg.pkt_syn     <= s_pkt_syn;
            item_reg.pkt_fin     <= s_pkt_fin;
            item_reg.ack_seq     <= s_ack_seq;
            item_reg.peer_rwnd   <= s_peer_rwnd;
        end
        if (advance) res_reg <= res_next;
    end

    assign m_valid        = res_valid_reg;
    assign m_action       = res_reg.action;
    assign m_tx_seq       = res_reg.tx_seq;
    assign m_tx_is_fin    = res_reg.tx_is_fin;
    assign m_in_flight    = res_reg.in_flight;
    assign m_is_connected = res_reg.is_connected;
    assign m_is_finished  = res_reg.is_finished;
    assign m_dup_ack      = res_reg.dup_ack;

endmodule
